// ===== hw/rtl/rgb_led_chain_pwm_encoder_defines.svh =====
// Assertion macros shared by the LED chain PWM encoder RTL.
`ifndef RGB_LED_CHAIN_PWM_ENCODER_DEFINES_SVH
`define RGB_LED_CHAIN_PWM_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RLCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RLCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rlce_pkg.sv =====
// Types, constants and the brightness table of the LED chain PWM encoder.
package rlce_pkg;

    localparam int LED_IDX_W   = 3;
    localparam int CH_W        = 8;
    localparam int COLOR_W     = 3 * CH_W;
    localparam int BIT_CNT_W   = 5;
    localparam int RST_CNT_W   = 6;
    localparam int BRIGHT_W    = 6;
    localparam int TAN_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int MAX_IDX_SLOTS = 2 ** LED_IDX_W;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(COLOR_W - 1);
    localparam logic [BRIGHT_W-1:0]  MAX_ANGLE = BRIGHT_W'(45);

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_DUTY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DUTY = 2'd3;

    typedef struct packed {
        logic                scale_enable;
        logic [BRIGHT_W-1:0] brightness;
        logic [CH_W-1:0]     one_duty;
        logic [CH_W-1:0]     zero_duty;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic tick;
        logic hold;
    } t_slot_ctrl;

    typedef struct packed {
        logic sending;
        logic out_valid;
    } t_slot_status;

    // floor(tan(b degrees) * 2^16); angles above 45 read as 45
    function automatic logic [TAN_W-1:0] tan_q16(input logic [BRIGHT_W-1:0] b);
        logic [TAN_W-1:0] t;
        case (b)
            6'd0:  t = 17'd0;     6'd1:  t = 17'd1143;  6'd2:  t = 17'd2288;
            6'd3:  t = 17'd3434;  6'd4:  t = 17'd4582;  6'd5:  t = 17'd5733;
            6'd6:  t = 17'd6888;  6'd7:  t = 17'd8046;  6'd8:  t = 17'd9210;
            6'd9:  t = 17'd10379; 6'd10: t = 17'd11555; 6'd11: t = 17'd12738;
            6'd12: t = 17'd13930; 6'd13: t = 17'd15130; 6'd14: t = 17'd16339;
            6'd15: t = 17'd17560; 6'd16: t = 17'd18792; 6'd17: t = 17'd20036;
            6'd18: t = 17'd21293; 6'd19: t = 17'd22565; 6'd20: t = 17'd23853;
            6'd21: t = 17'd25156; 6'd22: t = 17'd26478; 6'd23: t = 17'd27818;
            6'd24: t = 17'd29178; 6'd25: t = 17'd30559; 6'd26: t = 17'd31964;
            6'd27: t = 17'd33392; 6'd28: t = 17'd34846; 6'd29: t = 17'd36327;
            6'd30: t = 17'd37837; 6'd31: t = 17'd39378; 6'd32: t = 17'd40951;
            6'd33: t = 17'd42559; 6'd34: t = 17'd44204; 6'd35: t = 17'd45888;
            6'd36: t = 17'd47614; 6'd37: t = 17'd49384; 6'd38: t = 17'd51202;
            6'd39: t = 17'd53070; 6'd40: t = 17'd54991; 6'd41: t = 17'd56969;
            6'd42: t = 17'd59008; 6'd43: t = 17'd61113; 6'd44: t = 17'd63287;
            default: t = 17'd65536;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/rlce_color_store.sv =====
// Per-LED color registers: one write port, one read port, cleared by reset.
module rlce_color_store
    import rlce_pkg::*;
#(
    parameter int NUM_LEDS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [LED_IDX_W-1:0]                 i_wr_idx,
    input  logic [COLOR_W-1:0]                   i_wr_color,
    input  logic [$clog2(NUM_LEDS+1)-1:0]        i_rd_idx,
    output logic [COLOR_W-1:0]                   o_rd_color
);

    localparam int LED_CNT_W   = $clog2(NUM_LEDS + 1);
    // Only indexes the write field can reach ever hold a color
    localparam int STORE_DEPTH = (NUM_LEDS < MAX_IDX_SLOTS) ? NUM_LEDS : MAX_IDX_SLOTS;
    localparam int STORE_IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [COLOR_W-1:0] r_mem [STORE_DEPTH];
    logic               wr_hit;
    logic               rd_hit;

    assign wr_hit = i_wr_en && ({1'b0, i_wr_idx} < (LED_IDX_W+1)'(STORE_DEPTH));
    assign rd_hit = i_rd_idx < LED_CNT_W'(STORE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_mem[k] <= '0;
            end
        end else if (wr_hit) begin
            r_mem[i_wr_idx[STORE_IDX_W-1:0]] <= i_wr_color;
        end
    end

    assign o_rd_color = rd_hit ? r_mem[i_rd_idx[STORE_IDX_W-1:0]] : '0;

endmodule

// ===== hw/rtl/rlce_scaler.sv =====
// Brightness scaling of one packed GRB color by the tangent table.
module rlce_scaler
    import rlce_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic [COLOR_W-1:0] i_color,
    output logic [COLOR_W-1:0] o_color
);

    logic [TAN_W-1:0]      tan_val;
    logic [CH_W+TAN_W-1:0] prod [3];
    logic [COLOR_W-1:0]    scaled;

    assign tan_val = tan_q16(i_cfg.brightness);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = {{TAN_W{1'b0}}, i_color[c*CH_W +: CH_W]} * {{CH_W{1'b0}}, tan_val};
            // truncate: keep bits 23..16, the product never exceeds 255 << 16
            scaled[c*CH_W +: CH_W] = prod[c][16 +: CH_W];
        end
    end

    assign o_color = i_cfg.scale_enable ? scaled : i_color;

endmodule

// ===== hw/rtl/rlce_slot_gen.sv =====
// Frame sequencer: LED, bit and reset-slot counters, bit shifter, result register.
module rlce_slot_gen
    import rlce_pkg::*;
#(
    parameter int NUM_LEDS    = 8,
    parameter int RESET_SLOTS = 50
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_slot_ctrl                        i_ctrl,
    input  t_cfg                              i_cfg,
    input  logic [COLOR_W-1:0]                i_led_color,
    output logic [$clog2(NUM_LEDS+1)-1:0]     o_led_idx,
    output t_slot_status                      o_status,
    output logic [CH_W-1:0]                   o_duty,
    output logic                              o_data_slot,
    output logic                              o_last
);

    localparam int LED_CNT_W = $clog2(NUM_LEDS + 1);
    localparam logic [LED_CNT_W-1:0] LED_END  = LED_CNT_W'(NUM_LEDS);
    localparam logic [RST_CNT_W-1:0] RST_LAST = RST_CNT_W'(RESET_SLOTS - 1);

    logic                  r_sending,  n_sending;
    logic [LED_CNT_W-1:0]  r_led_cnt,  n_led_cnt;
    logic [BIT_CNT_W-1:0]  r_bit_cnt,  n_bit_cnt;
    logic [RST_CNT_W-1:0]  r_rst_cnt,  n_rst_cnt;
    logic [COLOR_W-1:0]    r_shift,    n_shift;
    logic                  r_out_valid, n_out_valid;
    logic [CH_W-1:0]       r_duty,     n_duty;
    logic                  r_data_slot, n_data_slot;
    logic                  r_last,     n_last;

    logic [COLOR_W-1:0]    load_color;
    logic [COLOR_W-1:0]    word;

    rlce_scaler u_scaler (
        .i_cfg   (i_cfg),
        .i_color (i_led_color),
        .o_color (load_color)
    );

    assign word = (r_bit_cnt == '0) ? load_color : r_shift;

    always_comb begin
        n_sending   = r_sending;
        n_led_cnt   = r_led_cnt;
        n_bit_cnt   = r_bit_cnt;
        n_rst_cnt   = r_rst_cnt;
        n_shift     = r_shift;
        n_out_valid = 1'b0;
        n_duty      = r_duty;
        n_data_slot = r_data_slot;
        n_last      = r_last;
        if (i_ctrl.start && !r_sending) begin
            n_sending = 1'b1;
            n_led_cnt = '0;
            n_bit_cnt = '0;
            n_rst_cnt = '0;
            n_shift   = '0;
        end else if (i_ctrl.tick && r_sending) begin
            n_out_valid = 1'b1;
            if (r_led_cnt < LED_END) begin
                n_shift     = {word[COLOR_W-2:0], 1'b0};
                n_duty      = word[COLOR_W-1] ? i_cfg.one_duty : i_cfg.zero_duty;
                n_data_slot = 1'b1;
                n_last      = 1'b0;
                if (r_bit_cnt == LAST_BIT) begin
                    n_bit_cnt = '0;
                    n_led_cnt = r_led_cnt + 1'b1;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                end
            end else begin
                n_duty      = '0;
                n_data_slot = 1'b0;
                if (r_rst_cnt == RST_LAST) begin
                    n_last    = 1'b1;
                    n_sending = 1'b0;
                    n_led_cnt = '0;
                    n_bit_cnt = '0;
                    n_rst_cnt = '0;
                end else begin
                    n_last    = 1'b0;
                    n_rst_cnt = r_rst_cnt + 1'b1;
                end
            end
        end else if (i_ctrl.hold) begin
            // result stalled at the output: hold it
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_led_cnt   <= '0;
            r_bit_cnt   <= '0;
            r_rst_cnt   <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sending   <= n_sending;
            r_led_cnt   <= n_led_cnt;
            r_bit_cnt   <= n_bit_cnt;
            r_rst_cnt   <= n_rst_cnt;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty      <= n_duty;
        r_data_slot <= n_data_slot;
        r_last      <= n_last;
    end

    assign o_led_idx          = r_led_cnt;
    assign o_status.sending   = r_sending;
    assign o_status.out_valid = r_out_valid;
    assign o_duty             = r_duty;
    assign o_data_slot        = r_data_slot;
    assign o_last             = r_last;

endmodule

// ===== hw/rtl/rgb_led_chain_pwm_encoder.sv =====
// Addressable RGB LED chain PWM encoder top level: input register, config, store, sequencer.
//
// Holds one GRB color per LED and, once a frame is started, turns each tick
// beat into one PWM duty slot: 24 data slots per LED, green then red then
// blue, MSB first (one_duty for a one, zero_duty for a zero), followed by
// RESET_SLOTS reset slots of duty zero, the final one flagged by o_last.
// With scale_enable set, each channel is multiplied by floor(tan(b deg)*2^16)
// and truncated to 8 bits as the LED's first bit goes out; brightness above
// 45 acts as 45. Color writes and start requests give no result beat; a
// start while a frame runs, a tick while idle, request code 3 and color
// writes to an index at or beyond NUM_LEDS are dropped. Throughput is one
// input beat per cycle while o_stall is low. A tick passes the input
// register, then the result register fed by the color store read, one
// 8x17 multiply per channel and the slot counters, which drives o_valid;
// both registers stall together when the result register is full and
// o_valid is stalled.
// The color store is cleared by reset and needs no sweep. Write config
// only while no frame is running and no beat is in flight.
module rgb_led_chain_pwm_encoder
    import rlce_pkg::*;
#(
    parameter int NUM_LEDS    = 8,
    parameter int RESET_SLOTS = 50
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic [LED_IDX_W-1:0]  i_led_index,
    input  logic [CH_W-1:0]       i_red,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_blue,
    // slot channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CH_W-1:0]       o_duty,
    output logic                  o_data_slot,
    output logic                  o_last
);

`include "rgb_led_chain_pwm_encoder_defines.svh"

    localparam int LED_CNT_W = $clog2(NUM_LEDS + 1);

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    logic [1:0]            r_req;
    logic [LED_IDX_W-1:0]  r_idx;
    logic [COLOR_W-1:0]    r_color;

    logic                  in_accept;
    logic                  advance;
    logic                  consume;
    t_slot_ctrl            slot_ctrl;
    t_slot_status          slot_status;
    logic [LED_CNT_W-1:0]  rd_idx;
    logic [COLOR_W-1:0]    rd_color;
    logic                  store_wr;

    // Config registers: plain writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_enable <= 1'b1;
            r_cfg.brightness   <= MAX_ANGLE;
            r_cfg.one_duty     <= CH_W'(26);
            r_cfg.zero_duty    <= CH_W'(13);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_SCALE_EN:  r_cfg.scale_enable <= i_cfg_wr_data[0];
                CFG_BRIGHT:    r_cfg.brightness   <= i_cfg_wr_data[BRIGHT_W-1:0];
                CFG_ONE_DUTY:  r_cfg.one_duty     <= i_cfg_wr_data;
                CFG_ZERO_DUTY: r_cfg.zero_duty    <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // The input register drains whenever the result register can take a beat
    assign advance   = !slot_status.out_valid || !i_stall;
    assign consume   = r_in_valid && advance;
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: GRB packing as stored
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req   <= i_req_type;
            r_idx   <= i_led_index;
            r_color <= {i_green, i_red, i_blue};
        end
    end

    assign store_wr        = consume && (r_req == REQ_WRITE);
    assign slot_ctrl.start = consume && (r_req == REQ_START);
    assign slot_ctrl.tick  = consume && (r_req == REQ_TICK);
    // Keep the result beat only while the receiver stalls it
    assign slot_ctrl.hold  = slot_status.out_valid && i_stall;

    rlce_color_store #(
        .NUM_LEDS (NUM_LEDS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (store_wr),
        .i_wr_idx   (r_idx),
        .i_wr_color (r_color),
        .i_rd_idx   (rd_idx),
        .o_rd_color (rd_color)
    );

    rlce_slot_gen #(
        .NUM_LEDS    (NUM_LEDS),
        .RESET_SLOTS (RESET_SLOTS)
    ) u_slot_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (slot_ctrl),
        .i_cfg       (r_cfg),
        .i_led_color (rd_color),
        .o_led_idx   (rd_idx),
        .o_status    (slot_status),
        .o_duty      (o_duty),
        .o_data_slot (o_data_slot),
        .o_last      (o_last)
    );

    assign o_valid = slot_status.out_valid;

    // A reset slot carries duty zero, and the final one ends the frame
    `RLCE_ASSERT_IMP(a_last_is_reset_slot, o_valid && o_last, !o_data_slot && (o_duty == '0), "last slot is not a zero-duty reset slot")
    // A stalled result holds the input register
    `RLCE_ASSERT_IMP(a_hold_on_stall, o_valid && i_stall && r_in_valid, o_stall, "input register drained into a stalled result")
    // Marking the final slot drops the frame
    `RLCE_ASSERT_IMP(a_last_ends_frame, o_valid && o_last, !slot_status.sending, "frame still running after last slot")
    // A result only follows a tick taken while a frame runs
    `RLCE_ASSERT_NXT(a_result_from_tick, !slot_ctrl.tick && !o_valid, !o_valid, "result beat without a tick")

endmodule
